// ===== rtl/set_assoc_cache_with_prefetch_assert.svh =====
// Assertion macros used by the checker file
`ifndef SET_ASSOC_CACHE_WITH_PREFETCH_ASSERT_SVH
`define SET_ASSOC_CACHE_WITH_PREFETCH_ASSERT_SVH

// same-cycle implication, off during reset
`define SAC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sac assertion failed");

// next-cycle implication, off during reset
`define SAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sac assertion failed");

// next-cycle implication that also holds across reset
`define SAC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sac assertion failed");

`endif

// ===== rtl/sac_pkg.sv =====
package sac_pkg;

   // default geometry
   localparam int DEF_SET_COUNT    = 256;
   localparam int DEF_WAY_COUNT    = 8;
   localparam int DEF_ADDR_WIDTH   = 48;
   localparam int DEF_MAX_PREFETCH = 15;

   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 4;
   localparam int FETCH_W     = 5;
   // set_index_bits is 4 bits, so at most 15 raw set bits
   localparam int RAW_SET_W   = 15;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_INDEX_BITS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LRU_MODE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFETCH_LINES = 3'd4;

   typedef struct packed {
      logic [3:0] set_index_bits;
      logic [3:0] offset_bits;
      logic [3:0] ways_in_use;
      logic       lru_mode;
      logic [3:0] prefetch_lines;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      set_index_bits: 4'd0,
      offset_bits:    4'd6,
      ways_in_use:    4'd1,
      lru_mode:       1'b0,
      prefetch_lines: 4'd0
   };

   typedef enum logic [1:0] {F_IDLE, F_LOC, F_RED, F_PUSH} front_state_type;
   typedef enum logic [1:0] {B_IDLE, B_WAIT, B_EMIT} back_state_type;

   // command from the sequencer to one cache
   typedef struct packed {
      logic valid;
      logic probe;
      logic lru;
   } cache_cmd_type;

   // status from one cache
   typedef struct packed {
      logic ready;
      logic done;
      logic hit;
   } cache_stat_type;

endpackage

// ===== rtl/sac_channels.sv =====
interface sac_req_if #(parameter int ADDR_WIDTH = 48);
   logic                  valid;
   logic                  ready;
   logic                  op;
   logic [ADDR_WIDTH-1:0] address;
   modport source (output valid, op, address, input ready);
   modport sink   (input valid, op, address, output ready);
endinterface

interface sac_rsp_if import sac_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               plain_hit;
   logic               plain_fetch;
   logic               memory_write;
   logic               prefetch_side_hit;
   logic [FETCH_W-1:0] prefetch_side_fetches;
   modport source (output valid, plain_hit, plain_fetch, memory_write, prefetch_side_hit,
                   prefetch_side_fetches, input ready);
   modport sink   (input valid, plain_hit, plain_fetch, memory_write, prefetch_side_hit,
                   prefetch_side_fetches, output ready);
endinterface

interface sac_csr_if import sac_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sac_queue.sv =====
module sac_queue import sac_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = cnt_ff != CNT_W'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/sac_front.sv =====
module sac_front import sac_pkg::*; #(
   parameter int SET_COUNT    = DEF_SET_COUNT,
   parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
   parameter int MAX_PREFETCH = DEF_MAX_PREFETCH,
   parameter int SET_W        = 8,
   parameter int ENT_W        = 59
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   sac_req_if.sink          req,
   output logic             push_valid,
   input  logic             push_ready,
   output logic [ENT_W-1:0] push_data
);
   localparam int CNT_W     = (MAX_PREFETCH > 0) ? $clog2(MAX_PREFETCH + 1) : 1;
   localparam bit POW2      = (SET_COUNT & (SET_COUNT - 1)) == 0;
   localparam int RED_STEPS = 4;
   localparam int ROUNDS    = (RAW_SET_W + RED_STEPS - 1) / RED_STEPS;
   localparam int RND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam int RED_W     = RAW_SET_W + $clog2(SET_COUNT) + 1;
   localparam logic [RAW_SET_W-1:0] SET_MASK = RAW_SET_W'(SET_COUNT - 1);

   front_state_type        state_ff, state_in;
   logic                   op_ff, op_in;
   logic [ADDR_WIDTH-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]       idx_ff, idx_in, cnt_ff, cnt_in;
   logic [RAW_SET_W-1:0]   rem_ff, rem_in;
   logic [ADDR_WIDTH-1:0]  tag_ff, tag_in;
   logic [RND_W-1:0]       rnd_ff, rnd_in;

   logic [ADDR_WIDTH-1:0]  block, blk_tag, step;
   logic [RAW_SET_W:0]     raw_mask_wide;
   logic [RAW_SET_W-1:0]   raw, red, set_full;
   logic [RED_W-1:0]       thr;
   logic [CNT_W-1:0]       pf_count;
   logic                   last_blk;
   int                     k;

   // address split of the current block
   always_comb begin
      block         = cur_ff >> cfg.offset_bits;
      raw_mask_wide = ((RAW_SET_W + 1)'(1) << cfg.set_index_bits) - 1'b1;
      raw           = block[RAW_SET_W-1:0] & raw_mask_wide[RAW_SET_W-1:0];
      blk_tag       = block >> cfg.set_index_bits;
      step          = ADDR_WIDTH'(1) << cfg.offset_bits;
      pf_count      = CNT_W'((int'(cfg.prefetch_lines) > MAX_PREFETCH) ?
                             MAX_PREFETCH : int'(cfg.prefetch_lines));
      last_blk      = idx_ff == cnt_ff;
      set_full      = POW2 ? (rem_ff & SET_MASK) : rem_ff;
   end

   // a few restoring subtract steps of the set reduction per cycle
   always_comb begin
      red = rem_ff;
      thr = '0;
      k   = 0;
      for (int j = RED_STEPS - 1; j >= 0; j--) begin
         k   = int'(rnd_ff) * RED_STEPS + j;
         thr = RED_W'(SET_COUNT) << k;
         if (k < RAW_SET_W && RED_W'(red) >= thr) begin
            red = red - thr[RAW_SET_W-1:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: if (req.valid) state_in = F_LOC;
         F_LOC:  state_in = POW2 ? F_PUSH : F_RED;
         F_RED:  if (rnd_ff == '0) state_in = F_PUSH;
         F_PUSH: if (push_ready) state_in = last_blk ? F_IDLE : F_LOC;
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         F_IDLE:  req.ready  = 1'b1;
         F_PUSH:  push_valid = 1'b1;
         default: ;
      endcase
   end

   assign push_data = {op_ff, idx_ff != '0, last_blk, set_full[SET_W-1:0], tag_ff};

   // datapath registers
   always_comb begin
      op_in  = op_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      tag_in = tag_ff;
      rnd_in = rnd_ff;
      case (state_ff)
         F_IDLE: begin
            op_in  = req.op;
            cur_in = req.address;
            idx_in = '0;
            cnt_in = pf_count;
         end
         F_LOC: begin
            rem_in = raw;
            tag_in = blk_tag;
            rnd_in = RND_W'(ROUNDS - 1);
         end
         F_RED: begin
            rem_in = red;
            rnd_in = rnd_ff - 1'b1;
         end
         F_PUSH: begin
            if (push_ready && !last_blk) begin
               cur_in = cur_ff + step;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      tag_ff <= tag_in;
      rnd_ff <= rnd_in;
   end

endmodule

// ===== rtl/sac_cache.sv =====
module sac_cache import sac_pkg::*; #(
   parameter int SET_COUNT  = DEF_SET_COUNT,
   parameter int WAY_COUNT  = DEF_WAY_COUNT,
   parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
   parameter int SET_W      = 8,
   parameter int NW_W       = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cache_cmd_type         cmd,
   input  logic [SET_W-1:0]      cmd_set,
   input  logic [ADDR_WIDTH-1:0] cmd_tag,
   input  logic [NW_W-1:0]       nways,
   output cache_stat_type        stat
);
   localparam int RANK_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
   localparam int W_W    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
   localparam logic [RANK_W-1:0] MAXR = RANK_W'(WAY_COUNT - 1);

   typedef logic [WAY_COUNT-1:0][ADDR_WIDTH-1:0] tag_row_type;
   typedef logic [WAY_COUNT-1:0][RANK_W-1:0]     rank_row_type;

   // one row per set
   tag_row_type            tag_mem   [SET_COUNT];
   logic [WAY_COUNT-1:0]   valid_mem [SET_COUNT];
   rank_row_type           rank_mem  [SET_COUNT];

   logic                   clr_busy_ff, clr_busy_in;
   logic [SET_W-1:0]       clr_ff, clr_in;
   logic                   stg_valid_ff, stg_probe_ff, stg_lru_ff;
   logic [SET_W-1:0]       stg_set_ff;
   logic [ADDR_WIDTH-1:0]  stg_tag_ff;
   tag_row_type            rd_tag_ff;
   logic [WAY_COUNT-1:0]   rd_valid_ff;
   rank_row_type           rd_rank_ff;

   logic [WAY_COUNT-1:0]   use_w;
   logic                   pre, hit, emp, upd;
   logic [W_W-1:0]         hit_way, emp_way, vic, tgt;
   logic [RANK_W-1:0]      cut_rank;
   tag_row_type            new_tag;
   logic [WAY_COUNT-1:0]   new_valid;
   rank_row_type           new_rank;
   logic                   wr_en;
   logic [SET_W-1:0]       wr_set;

   // lookup, victim choice and age update on the row read last cycle
   always_comb begin
      pre     = 1'b1;
      hit     = 1'b0;
      hit_way = '0;
      emp     = 1'b0;
      emp_way = '0;
      vic     = '0;
      for (int w = 0; w < WAY_COUNT; w++) begin
         use_w[w] = w < int'(nways);
         if (use_w[w] && pre && rd_valid_ff[w] && !hit && rd_tag_ff[w] == stg_tag_ff) begin
            hit     = 1'b1;
            hit_way = W_W'(w);
         end
         if (use_w[w]) pre = pre & rd_valid_ff[w];
         if (use_w[w] && !rd_valid_ff[w] && !emp) begin
            emp     = 1'b1;
            emp_way = W_W'(w);
         end
      end
      // oldest way, ties to lowest index
      for (int w = 1; w < WAY_COUNT; w++) begin
         if (use_w[w] && rd_rank_ff[w] > rd_rank_ff[vic]) vic = W_W'(w);
      end
      tgt      = hit ? hit_way : (emp ? emp_way : vic);
      cut_rank = hit ? rd_rank_ff[tgt] : MAXR;
      upd      = stg_valid_ff && (!hit || (stg_lru_ff && !stg_probe_ff));

      new_tag   = rd_tag_ff;
      new_valid = rd_valid_ff;
      new_rank  = rd_rank_ff;
      for (int v = 0; v < WAY_COUNT; v++) begin
         if (W_W'(v) == tgt) begin
            new_rank[v] = '0;
            if (!hit) begin
               new_tag[v]   = stg_tag_ff;
               new_valid[v] = 1'b1;
            end
         end else if (use_w[v] && rd_valid_ff[v] && rd_rank_ff[v] < cut_rank &&
                      rd_rank_ff[v] < MAXR) begin
            new_rank[v] = rd_rank_ff[v] + 1'b1;
         end
      end
   end

   assign stat.ready = !clr_busy_ff;
   assign stat.done  = stg_valid_ff;
   assign stat.hit   = hit;

   assign wr_en  = clr_busy_ff || upd;
   assign wr_set = clr_busy_ff ? clr_ff : stg_set_ff;

   // clearing pass after reset
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_in      = clr_ff;
      if (clr_busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == SET_W'(SET_COUNT - 1)) clr_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_ff       <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_ff       <= clr_in;
         stg_valid_ff <= cmd.valid;
      end
   end

   // command stage and registered row read
   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         stg_probe_ff <= cmd.probe;
         stg_lru_ff   <= cmd.lru;
         stg_set_ff   <= cmd_set;
         stg_tag_ff   <= cmd_tag;
         rd_tag_ff    <= tag_mem[cmd_set];
         rd_valid_ff  <= valid_mem[cmd_set];
         rd_rank_ff   <= rank_mem[cmd_set];
      end
   end

   always_ff @(posedge clock) begin
      if (upd && !clr_busy_ff) begin
         tag_mem[stg_set_ff] <= new_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         valid_mem[wr_set] <= clr_busy_ff ? '0 : new_valid;
         rank_mem[wr_set]  <= clr_busy_ff ? '0 : new_rank;
      end
   end

endmodule

// ===== rtl/sac_back.sv =====
module sac_back import sac_pkg::*; #(
   parameter int WAY_COUNT  = DEF_WAY_COUNT,
   parameter int ADDR_WIDTH = DEF_ADDR_WIDTH,
   parameter int SET_W      = 8,
   parameter int ENT_W      = 59,
   parameter int NW_W       = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [ENT_W-1:0]      pop_data,
   output cache_cmd_type         plain_cmd,
   output cache_cmd_type         pref_cmd,
   output logic [SET_W-1:0]      cmd_set,
   output logic [ADDR_WIDTH-1:0] cmd_tag,
   output logic [NW_W-1:0]       nways,
   input  cache_stat_type        plain_stat,
   input  cache_stat_type        pref_stat,
   sac_rsp_if.source             rsp
);
   back_state_type      state_ff, state_in;
   logic                last_ff, last_in, dem_ff, dem_in, op_ff, op_in;
   logic                phit_ff, phit_in, qhit_ff, qhit_in;
   logic [FETCH_W-1:0]  fetch_ff, fetch_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_phit_ff, rsp_mwr_ff, rsp_qhit_ff;
   logic [FETCH_W-1:0]  rsp_fetch_ff;

   logic                ent_op, ent_probe, ent_last, take, skip, load;

   assign {ent_op, ent_probe, ent_last, cmd_set, cmd_tag} = pop_data;

   assign nways = NW_W'((cfg.ways_in_use == '0) ? 1 :
                        (int'(cfg.ways_in_use) > WAY_COUNT) ? WAY_COUNT :
                        int'(cfg.ways_in_use));

   assign take = pop_valid && plain_stat.ready && pref_stat.ready;
   assign skip = ent_probe && qhit_ff;
   assign load = (state_ff == B_EMIT) && (!rsp_valid_ff || rsp.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (take) begin
               if (!skip)         state_in = B_WAIT;
               else if (ent_last) state_in = B_EMIT;
            end
         end
         B_WAIT:  if (pref_stat.done) state_in = last_ff ? B_EMIT : B_IDLE;
         B_EMIT:  if (load) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready = 1'b0;
      plain_cmd = '0;
      pref_cmd  = '0;
      case (state_ff)
         B_IDLE: begin
            pop_ready = plain_stat.ready && pref_stat.ready;
            if (take && !skip) begin
               plain_cmd.valid = !ent_probe;
               plain_cmd.lru   = cfg.lru_mode;
               pref_cmd.valid  = 1'b1;
               pref_cmd.probe  = ent_probe;
               pref_cmd.lru    = cfg.lru_mode;
            end
         end
         default: ;
      endcase
   end

   // per-item bookkeeping
   always_comb begin
      last_in  = last_ff;
      dem_in   = dem_ff;
      op_in    = op_ff;
      phit_in  = phit_ff;
      qhit_in  = qhit_ff;
      fetch_in = fetch_ff;
      if (state_ff == B_IDLE && take) begin
         last_in = ent_last;
         dem_in  = !ent_probe;
         if (!ent_probe) op_in = ent_op;
      end
      if (state_ff == B_WAIT && pref_stat.done) begin
         if (dem_ff) begin
            phit_in  = plain_stat.hit;
            qhit_in  = pref_stat.hit;
            fetch_in = pref_stat.hit ? '0 : FETCH_W'(1);
         end else if (!pref_stat.hit && fetch_ff != '1) begin
            fetch_in = fetch_ff + 1'b1;
         end
      end
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)           rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   assign rsp.valid                 = rsp_valid_ff;
   assign rsp.plain_hit             = rsp_phit_ff;
   assign rsp.plain_fetch           = !rsp_phit_ff;
   assign rsp.memory_write          = rsp_mwr_ff;
   assign rsp.prefetch_side_hit     = rsp_qhit_ff;
   assign rsp.prefetch_side_fetches = rsp_fetch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         qhit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         qhit_ff      <= qhit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      dem_ff   <= dem_in;
      op_ff    <= op_in;
      phit_ff  <= phit_in;
      fetch_ff <= fetch_in;
      if (load) begin
         rsp_phit_ff  <= phit_ff;
         rsp_mwr_ff   <= op_ff;
         rsp_qhit_ff  <= qhit_ff;
         rsp_fetch_ff <= fetch_ff;
      end
   end

endmodule

// ===== rtl/set_assoc_cache_with_prefetch.sv =====
// Pair of set-associative caches (plain, and with next-line prefetch) fed by one
// access stream; one result word per access. The front splits each access into
// its demand block and the following prefetch blocks (set index and tag); the
// back runs the demand block through both caches, the prefetch blocks only
// through the prefetch cache. Every block costs one read-modify-write of a set
// row in each cache it goes through. The front splits each block, then hands it
// over; with P the prefetch lines configured (capped at MAX_PREFETCH), an access
// yields P + 1 blocks. The front takes a new access only once it has handed over
// every block of the last one, while the back may still be working on it. On a
// prefetch-side hit the back drops the probe blocks, but the front still splits
// them; a non-power-of-two SET_COUNT adds set reduction rounds to each block in
// the front. After reset a clearing pass over all SET_COUNT set rows runs before
// the first access is processed; registers can be written meanwhile. Registers
// must be written only while the block is idle; the block does not enforce this.
module set_assoc_cache_with_prefetch import sac_pkg::*; #(
   parameter int SET_COUNT    = DEF_SET_COUNT,
   parameter int WAY_COUNT    = DEF_WAY_COUNT,
   parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH,
   parameter int MAX_PREFETCH = DEF_MAX_PREFETCH
) (
   input logic       clock,
   input logic       reset,
   sac_req_if.sink   req_ch,
   sac_rsp_if.source rsp_ch,
   sac_csr_if.sink   csr_ch
);
   localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
   localparam int ENT_W = 3 + SET_W + ADDR_WIDTH;
   localparam int NW_W  = $clog2(WAY_COUNT + 1);

   cfg_type               cfg_ff, cfg_in;
   logic                  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
   logic [ENT_W-1:0]      q_push_data, q_pop_data;
   cache_cmd_type         plain_cmd, pref_cmd;
   cache_stat_type        plain_stat, pref_stat;
   logic [SET_W-1:0]      cmd_set;
   logic [ADDR_WIDTH-1:0] cmd_tag;
   logic [NW_W-1:0]       nways;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SET_INDEX_BITS: cfg_in.set_index_bits = csr_ch.data;
            CSR_OFFSET_BITS:    cfg_in.offset_bits    = csr_ch.data;
            CSR_WAYS_IN_USE:    cfg_in.ways_in_use    = csr_ch.data;
            CSR_LRU_MODE:       cfg_in.lru_mode       = csr_ch.data[0];
            CSR_PREFETCH_LINES: cfg_in.prefetch_lines = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sac_front #(
      .SET_COUNT(SET_COUNT), .ADDR_WIDTH(ADDR_WIDTH), .MAX_PREFETCH(MAX_PREFETCH),
      .SET_W(SET_W), .ENT_W(ENT_W)
   ) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .req(req_ch),
      .push_valid(q_push_valid), .push_ready(q_push_ready), .push_data(q_push_data)
   );

   sac_queue #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push_valid(q_push_valid), .push_ready(q_push_ready), .push_data(q_push_data),
      .pop_valid(q_pop_valid), .pop_ready(q_pop_ready), .pop_data(q_pop_data)
   );

   sac_back #(
      .WAY_COUNT(WAY_COUNT), .ADDR_WIDTH(ADDR_WIDTH), .SET_W(SET_W), .ENT_W(ENT_W),
      .NW_W(NW_W)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .pop_valid(q_pop_valid), .pop_ready(q_pop_ready), .pop_data(q_pop_data),
      .plain_cmd(plain_cmd), .pref_cmd(pref_cmd), .cmd_set(cmd_set), .cmd_tag(cmd_tag),
      .nways(nways), .plain_stat(plain_stat), .pref_stat(pref_stat), .rsp(rsp_ch)
   );

   sac_cache #(
      .SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT), .ADDR_WIDTH(ADDR_WIDTH),
      .SET_W(SET_W), .NW_W(NW_W)
   ) u_plain (
      .clock(clock), .reset(reset), .cmd(plain_cmd), .cmd_set(cmd_set),
      .cmd_tag(cmd_tag), .nways(nways), .stat(plain_stat)
   );

   sac_cache #(
      .SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT), .ADDR_WIDTH(ADDR_WIDTH),
      .SET_W(SET_W), .NW_W(NW_W)
   ) u_pref (
      .clock(clock), .reset(reset), .cmd(pref_cmd), .cmd_set(cmd_set),
      .cmd_tag(cmd_tag), .nways(nways), .stat(pref_stat)
   );

endmodule

// ===== rtl/sac_checker.sv =====
`include "set_assoc_cache_with_prefetch_assert.svh"

module sac_assertions import sac_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               plain_hit,
   input logic               plain_fetch,
   input logic               memory_write,
   input logic               pref_hit,
   input logic [FETCH_W-1:0] pref_fetches
);

   // a stalled word stays valid and keeps plain_hit, memory_write and pref_fetches
   `SAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({plain_hit, memory_write, pref_fetches}))

   // plain side either hits or fetches the block
   `SAC_ASSERT_IMPLY(a_plain_excl, clock, reset, rsp_valid, plain_hit != plain_fetch)

   // prefetch side fetches nothing exactly when it hits
   `SAC_ASSERT_IMPLY(a_pref_fetch, clock, reset, rsp_valid, pref_hit == (pref_fetches == '0))

   // no word right after reset
   `SAC_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

bind set_assoc_cache_with_prefetch sac_assertions u_sac_assertions (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .plain_hit(rsp_ch.plain_hit),
   .plain_fetch(rsp_ch.plain_fetch),
   .memory_write(rsp_ch.memory_write),
   .pref_hit(rsp_ch.prefetch_side_hit),
   .pref_fetches(rsp_ch.prefetch_side_fetches)
);
